// ===== src/azl_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// azl_pkg
// Shared types, register indexes and helper functions of the two-axis
// auto-zero offset learner.
// ---------------------------------------------------------------------------
package azl_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_EXIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_DELTA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_NEEDED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LIMIT  = 3'd5;

    // Register reset values.
    localparam logic [14:0] ZONE_ENTER_RST    = 15'd35;
    localparam logic [14:0] ZONE_EXIT_RST     = 15'd50;
    localparam logic [15:0] ABORT_LEVEL_RST   = 16'd300;
    localparam logic [15:0] STABLE_DELTA_RST  = 16'd8;
    localparam logic [15:0] STABLE_NEEDED_RST = 16'd40;
    localparam logic [14:0] OFFSET_LIMIT_RST  = 15'd300;

    // Saturation value of the run counter.
    localparam logic [15:0] RUN_COUNT_MAX = 16'hFFFF;

    // Stream widths.
    localparam int SAMPLE_W  = 16;
    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int M_TDATA_W = 6 * SAMPLE_W;
    localparam int M_TUSER_W = 3;

    // Bit positions of the result flags in m_axis_tuser.
    localparam int USER_UPDATED = 0;
    localparam int USER_ZONE    = 1;
    localparam int USER_LOCKED  = 2;

    // Configuration register set, shared by both axes.
    typedef struct packed {
        logic [14:0] zone_enter;
        logic [14:0] zone_exit;
        logic [15:0] abort_level;
        logic [15:0] stable_delta;
        logic [15:0] stable_needed;
        logic [14:0] offset_limit;
    } azl_cfg_t;

    // Per-axis result after a beat has been processed.
    typedef struct packed {
        logic signed [15:0] offset;
        logic signed [15:0] corrected;
        logic               updated;
        logic               in_zone;
        logic               locked;
    } azl_axis_res_t;

    // Magnitude of a 16-bit signed value; -32768 gives 32768.
    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? (17'd0 - ext) : ext;
    endfunction

    // Magnitude of a 17-bit signed value that never reaches -65536.
    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        logic [16:0] u;
        u = v;
        return v[16] ? (17'd0 - u) : u;
    endfunction

    // Symmetric clamp of a candidate offset to +-lim.
    function automatic logic signed [15:0] clamp_off(input logic signed [17:0] v,
                                                     input logic [14:0] lim);
        logic signed [17:0] hi;
        logic signed [17:0] lo;
        logic signed [17:0] res;
        hi = $signed({3'b000, lim});
        lo = -hi;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res[15:0];
    endfunction

endpackage

// ===== src/azl_axis.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// azl_axis
// One axis of the offset learner: the learning state registers and the
// single-pass next-state logic that runs once per enabled beat.
// ---------------------------------------------------------------------------
module azl_axis
    import azl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  azl_cfg_t             cfg,
    input  logic                 en,
    input  logic signed [15:0]   sample,
    output azl_axis_res_t        res
);

    logic signed [15:0] offset_reg, offset_next;
    logic signed [15:0] ref_reg, ref_next;
    logic [15:0]        count_reg, count_next;
    logic               zone_reg, zone_next;
    logic               locked_reg, locked_next;
    logic               updated;

    logic signed [15:0] centered;
    logic [16:0]        cmag;
    logic               abort;
    logic signed [16:0] dev;
    logic               stable_cur;
    logic               enter_ev;
    logic               exit_ev;
    logic               stable_b;
    logic [15:0]        count_b;
    logic signed [15:0] ref_b;
    logic [15:0]        count_t;
    logic signed [15:0] ref_t;
    logic               hit;
    logic signed [19:0] sum7;
    logic signed [19:0] sum_adj;
    logic signed [16:0] avg;
    logic signed [15:0] lock_val;
    logic signed [15:0] avg_val;

    // Shared arithmetic: centered magnitude, deviation, run tracking, average.
    always_comb begin
        centered   = sample - offset_reg;
        cmag       = mag16(centered);
        abort      = mag16(sample) > {1'b0, cfg.abort_level};
        dev        = {sample[15], sample} - {ref_reg[15], ref_reg};
        stable_cur = mag17(dev) <= {1'b0, cfg.stable_delta};

        enter_ev = locked_reg && !zone_reg && (cmag <= {2'b00, cfg.zone_enter});
        exit_ev  = locked_reg && zone_reg && (cmag >= {2'b00, cfg.zone_exit});

        // Entering the zone restarts the run at this sample.
        stable_b = enter_ev ? 1'b1 : stable_cur;
        count_b  = enter_ev ? 16'd0 : count_reg;
        ref_b    = enter_ev ? sample : ref_reg;

        if (stable_b) begin
            count_t = (count_b == RUN_COUNT_MAX) ? count_b : count_b + 16'd1;
            ref_t   = ref_b;
        end else begin
            count_t = 16'd0;
            ref_t   = sample;
        end
        hit = count_t >= cfg.stable_needed;

        // (7 * offset + sample) / 8, truncated toward zero.
        sum7    = ({{4{offset_reg[15]}}, offset_reg} <<< 3)
                - {{4{offset_reg[15]}}, offset_reg}
                + {{4{sample[15]}}, sample};
        sum_adj = sum7[19] ? (sum7 + 20'sd7) : sum7;
        avg     = 17'(sum_adj >>> 3);

        lock_val = clamp_off({{2{sample[15]}}, sample}, cfg.offset_limit);
        avg_val  = clamp_off({avg[16], avg}, cfg.offset_limit);
    end

    // Next-state selection.
    always_comb begin
        offset_next = offset_reg;
        ref_next    = ref_reg;
        count_next  = count_reg;
        zone_next   = zone_reg;
        locked_next = locked_reg;
        updated     = 1'b0;
        if (abort) begin
            count_next = 16'd0;
            ref_next   = sample;
            zone_next  = 1'b0;
        end else if (!locked_reg) begin
            if (hit) begin
                offset_next = lock_val;
                locked_next = 1'b1;
                count_next  = 16'd0;
                ref_next    = sample;
                updated     = 1'b1;
            end else begin
                count_next = count_t;
                ref_next   = ref_t;
            end
        end else if (exit_ev) begin
            zone_next  = 1'b0;
            count_next = 16'd0;
            ref_next   = sample;
        end else if (zone_reg || enter_ev) begin
            zone_next = 1'b1;
            if (hit) begin
                offset_next = avg_val;
                count_next  = 16'd0;
                ref_next    = sample;
                updated     = (avg_val != offset_reg);
            end else begin
                count_next = count_t;
                ref_next   = ref_t;
            end
        end
    end

    // State registers, advanced once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            ref_reg    <= '0;
            count_reg  <= '0;
            zone_reg   <= 1'b0;
            locked_reg <= 1'b0;
        end else if (en) begin
            offset_reg <= offset_next;
            ref_reg    <= ref_next;
            count_reg  <= count_next;
            zone_reg   <= zone_next;
            locked_reg <= locked_next;
        end
    end

    // Result of this beat, taken from the updated state.
    always_comb begin
        res.offset    = offset_next;
        res.corrected = sample - offset_next;
        res.updated   = updated;
        res.in_zone   = zone_next;
        res.locked    = locked_next;
    end

    // Once locked, an axis stays locked until reset.
    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        locked_reg |=> locked_reg)
        else $error("axis lost its lock");

    // The zone is only ever entered on a locked axis.
    a_zone_needs_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        zone_reg |-> locked_reg)
        else $error("axis in zone while unlocked");

    // An unlocked axis still carries the reset offset.
    a_unlocked_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !locked_reg |-> (offset_reg == 16'sd0))
        else $error("offset changed before lock");

    // A reported update always comes with a locked result.
    a_update_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && updated) |-> locked_next)
        else $error("update reported on an unlocked axis");

endmodule

// ===== src/two_axis_auto_zero_offset_learner.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_axis_auto_zero_offset_learner
// Learns a zero offset for a steering and a longitudinal command stream and
// returns the offset-corrected commands.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample pair per beat (steering low, longitudinal high).
//   m_axis returns one result beat for every input beat, in order: the echoed
//   samples, both offsets, both corrected samples, and the longitudinal
//   update, zone and lock flags on m_axis_tuser.
//   A beat accepted into the input register is processed into the output
//   register, and m_axis_tvalid is high from then on. Throughput is one
//   beat per cycle while m_axis_tready is high; the per-axis compare, add
//   and clamp logic between the input register and the output register
//   sets that figure, with the learning state fed back within the same cycle.
//   When m_axis_tready is low the output beat holds and the input register
//   still takes one more beat; further beats then wait on s_axis_tready.
//   The cfg_* port writes a register on any edge with cfg_wr_en high; write
//   it only while no beat is in flight. Indexes beyond the list are ignored.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   both offsets, runs and locks, and empties the pipeline.
// ---------------------------------------------------------------------------
module two_axis_auto_zero_offset_learner
    import azl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // steer_sample, drive_sample
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // steer_echo, drive_echo, steer_zero,
                                                  // drive_zero, steer_corrected,
                                                  // drive_corrected
    output logic [M_TUSER_W-1:0]  m_axis_tuser    // drive_updated, drive_zone_active,
                                                  // drive_locked
);

    azl_cfg_t           cfg_reg;
    logic               in_valid_reg;
    logic signed [15:0] in_steer_reg;
    logic signed [15:0] in_drive_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic               out_free;
    logic               fire;
    azl_axis_res_t      steer_res;
    azl_axis_res_t      drive_res;

    // Configuration registers, masked to their widths.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zone_enter    <= ZONE_ENTER_RST;
            cfg_reg.zone_exit     <= ZONE_EXIT_RST;
            cfg_reg.abort_level   <= ABORT_LEVEL_RST;
            cfg_reg.stable_delta  <= STABLE_DELTA_RST;
            cfg_reg.stable_needed <= STABLE_NEEDED_RST;
            cfg_reg.offset_limit  <= OFFSET_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ZONE_ENTER:    cfg_reg.zone_enter    <= cfg_wdata[14:0];
                CFG_ZONE_EXIT:     cfg_reg.zone_exit     <= cfg_wdata[14:0];
                CFG_ABORT_LEVEL:   cfg_reg.abort_level   <= cfg_wdata;
                CFG_STABLE_DELTA:  cfg_reg.stable_delta  <= cfg_wdata;
                CFG_STABLE_NEEDED: cfg_reg.stable_needed <= cfg_wdata;
                CFG_OFFSET_LIMIT:  cfg_reg.offset_limit  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Handshake: the output register frees up when empty or being taken.
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_steer_reg <= s_axis_tdata[15:0];
            in_drive_reg <= s_axis_tdata[31:16];
        end
    end

    // The two learning axes.
    azl_axis u_steer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .en      (fire),
        .sample  (in_steer_reg),
        .res     (steer_res)
    );

    azl_axis u_drive (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .en      (fire),
        .sample  (in_drive_reg),
        .res     (drive_res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {drive_res.corrected, steer_res.corrected,
                           drive_res.offset, steer_res.offset,
                           in_drive_reg, in_steer_reg};
            m_user_reg <= {drive_res.locked, drive_res.in_zone, drive_res.updated};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // A stalled beat in the input register keeps its samples.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_steer_reg)
                                          && $stable(in_drive_reg)))
        else $error("input register changed while stalled");

    // The output register is only loaded from a beat that was present.
    a_out_from_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_free && !in_valid_reg) |=> !m_valid_reg)
        else $error("result beat appeared without an input beat");

    // A reported longitudinal update always comes with the lock flag.
    a_out_update_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[USER_UPDATED]) |-> m_user_reg[USER_LOCKED])
        else $error("update flag without lock flag");

    // The zone flag is never shown on an unlocked axis.
    a_out_zone_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[USER_ZONE]) |-> m_user_reg[USER_LOCKED])
        else $error("zone flag without lock flag");

endmodule
